// File: rtl/sdp_pkg.sv
`timescale 1ns / 1ps

package sdp_pkg;

    // Defaults for the top-level parameters
    localparam int HIGH_TICKS_DEF    = 2;
    localparam int TICKS_PER_MIN_DEF = 60000000;

    // Phase timer / low time width
    localparam int TIMER_W = 26;

    // Register reset values
    localparam int SPR_DEF = 200;
    localparam int RPM_DEF = 60;

    // Input modes
    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_STEPS = 3'd1;
    localparam logic [2:0] MODE_DEG   = 3'd2;
    localparam logic [2:0] MODE_REV   = 3'd3;
    localparam logic [2:0] MODE_ZERO  = 3'd4;
    localparam logic [2:0] MODE_STOP  = 3'd5;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_SPR     = 2'd0;
    localparam logic [1:0] REG_RPM     = 2'd1;
    localparam logic [1:0] REG_DIR_INV = 2'd2;
    localparam logic [1:0] REG_DRV_EN  = 2'd3;

    // Queue depths
    localparam int MID_DEPTH = 16;
    localparam int OUT_DEPTH = 2;

    // x/360 by reciprocal: estimate is q or q-1, fixed by one compare
    localparam int         DEG_PER_REV  = 360;
    localparam int         RECIP_SHIFT  = 38;
    localparam logic [29:0] DIV360_RECIP =
        30'((64'd1 << RECIP_SHIFT) / 64'(DEG_PER_REV));

    typedef enum logic [2:0] {
        K_NOP,
        K_TICK,
        K_MOVE,
        K_ZERO,
        K_STOP
    } t_kind;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] amount;
    } t_in_word;

    typedef struct packed {
        logic               step_level;
        logic               direction;
        logic               enable_n;
        logic signed [31:0] position;
        logic               busy_res;
        logic               rejected;
    } t_out_word;

    // Classified command handed from front to back
    typedef struct packed {
        t_kind       kind;
        logic        neg;
        logic [31:0] steps;
    } t_cmd;

endpackage

// File: rtl/sdp_fifo.sv
`timescale 1ns / 1ps

module sdp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + (AW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (AW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: rtl/sdp_front.sv
`timescale 1ns / 1ps

module sdp_front
    import sdp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_in_word    i_word,
    input  logic [15:0] i_spr,
    output logic        o_valid,
    output t_cmd        o_cmd
);

    // Eleven stages; every word advances each cycle.
    typedef struct packed {
        logic [2:0]  mode;
        logic        neg;
        logic [31:0] s13;
    } t_car;

    logic [10:0] r_vld;
    t_car        r_car [10];

    logic [31:0] amt_u;
    logic [47:0] rev_prod;
    logic [31:0] r1_mag;
    logic [61:0] r2_qp;
    logic [31:0] r2_mag;
    logic [23:0] r3_q;
    logic [9:0]  r3_r;
    logic [23:0] r4_q;
    logic [8:0]  r4_r;
    logic [39:0] r5_a;
    logic [24:0] r5_b;
    logic [54:0] r6_tp;
    logic [39:0] r6_a;
    logic [24:0] r6_b;
    logic [16:0] r7_t;
    logic [9:0]  r7_rb;
    logic [39:0] r7_a;
    logic [16:0] r8_t;
    logic [31:0] r8_a;
    logic [31:0] r9_sum;
    logic [31:0] r10_s;
    t_cmd        r_out;

    logic [23:0] q0;
    logic [31:0] q0x360;
    logic [16:0] t0;
    logic [24:0] t0x360;
    logic        r3_ge;
    t_kind       kind;

    assign amt_u    = i_word.amount;
    assign rev_prod = {16'b0, amt_u} * {32'b0, i_spr};
    assign q0       = r2_qp[61:RECIP_SHIFT];
    assign q0x360   = {8'b0, q0} * 32'(DEG_PER_REV);
    assign t0       = r6_tp[54:RECIP_SHIFT];
    assign t0x360   = {8'b0, t0} * 25'(DEG_PER_REV);
    assign r3_ge    = (r3_r >= 10'(DEG_PER_REV));

    always_comb begin
        unique case (r_car[9].mode)
            MODE_TICK:  kind = K_TICK;
            MODE_STEPS: kind = K_MOVE;
            MODE_DEG:   kind = K_MOVE;
            MODE_REV:   kind = K_MOVE;
            MODE_ZERO:  kind = K_ZERO;
            MODE_STOP:  kind = K_STOP;
            default:    kind = K_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[9:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        // stage 1: magnitude, steps / revolutions count
        r_car[0].mode <= i_word.mode;
        r_car[0].neg  <= amt_u[31];
        r_car[0].s13  <= (i_word.mode == MODE_STEPS) ? amt_u : rev_prod[31:0];
        r1_mag        <= amt_u[31] ? (32'd0 - amt_u) : amt_u;
        for (int i = 1; i < 10; i++) begin
            r_car[i] <= r_car[i-1];
        end
        // stage 2: |amount| / 360 estimate
        r2_qp  <= {30'b0, r1_mag} * {32'b0, DIV360_RECIP};
        r2_mag <= r1_mag;
        // stage 3: remainder
        r3_q <= q0;
        r3_r <= 10'(r2_mag - q0x360);
        // stage 4: correct quotient
        r4_q <= r3_q + 24'(r3_ge);
        r4_r <= r3_ge ? 9'(r3_r - 10'(DEG_PER_REV)) : r3_r[8:0];
        // stage 5: whole and fractional parts times steps_per_rev
        r5_a <= {16'b0, r4_q} * {24'b0, i_spr};
        r5_b <= {16'b0, r4_r} * {9'b0, i_spr};
        // stage 6: fractional part / 360 estimate
        r6_tp <= {30'b0, r5_b} * {25'b0, DIV360_RECIP};
        r6_a  <= r5_a;
        r6_b  <= r5_b;
        // stage 7
        r7_t  <= t0;
        r7_rb <= 10'(r6_b - t0x360);
        r7_a  <= r6_a;
        // stage 8
        r8_t <= r7_t + 17'(r7_rb >= 10'(DEG_PER_REV));
        r8_a <= r7_a[31:0];
        // stage 9: wrapped magnitude of degree move
        r9_sum <= r8_a + {15'b0, r8_t};
        // stage 10: signed step count
        if (r_car[8].mode == MODE_DEG) begin
            r10_s <= r_car[8].neg ? (32'd0 - r9_sum) : r9_sum;
        end else begin
            r10_s <= r_car[8].s13;
        end
        // stage 11: classify, split sign and magnitude
        r_out.kind  <= kind;
        r_out.neg   <= r10_s[31];
        r_out.steps <= r10_s[31] ? (32'd0 - r10_s) : r10_s;
    end

    assign o_valid = r_vld[10];
    assign o_cmd   = r_out;

endmodule

// File: rtl/sdp_div.sv
`timescale 1ns / 1ps

module sdp_div
    import sdp_pkg::*;
#(
    parameter int TICKS_PER_MINUTE = TICKS_PER_MIN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [15:0]        i_spr,
    input  logic [15:0]        i_rpm,
    output logic               o_busy,
    output logic [TIMER_W-1:0] o_low_time
);

    // Restoring divide, one quotient bit per cycle.
    localparam int                 CNT_W     = $clog2(TIMER_W);
    localparam logic [TIMER_W-1:0] DIVIDEND  = TIMER_W'(TICKS_PER_MINUTE);
    localparam logic [TIMER_W-1:0] LOW_RESET =
        TIMER_W'(TICKS_PER_MINUTE / (SPR_DEF * RPM_DEF));

    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;
    logic [31:0]        r_den;
    logic [31:0]        r_rem;
    logic [TIMER_W-1:0] r_quo;
    logic [TIMER_W-1:0] r_low;

    logic [32:0]        rem_sh;
    logic [32:0]        rem_sub;
    logic               ge;
    logic [31:0]        n_rem;
    logic [TIMER_W-1:0] n_quo;

    assign rem_sh  = {r_rem, DIVIDEND[r_cnt]};
    assign ge      = (rem_sh >= {1'b0, r_den});
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign n_rem   = ge ? rem_sub[31:0] : rem_sh[31:0];
    assign n_quo   = {r_quo[TIMER_W-2:0], ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_low  <= LOW_RESET;
        end else if (i_start) begin
            r_den  <= {16'b0, i_rpm} * {16'b0, i_spr};
            r_rem  <= '0;
            r_quo  <= '0;
            r_cnt  <= CNT_W'(TIMER_W - 1);
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_low  <= n_quo;
            end else begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    assign o_busy     = r_busy || i_start;
    assign o_low_time = r_low;

endmodule

// File: rtl/sdp_back.sv
`timescale 1ns / 1ps

module sdp_back
    import sdp_pkg::*;
#(
    parameter int HIGH_TICKS = HIGH_TICKS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_cmd               i_cmd,
    input  logic               i_out_full,
    input  logic [TIMER_W-1:0] i_low_time,
    input  logic               i_dir_invert,
    input  logic               i_drive_en,
    output logic               o_pop,
    output t_out_word          o_word
);

    localparam logic [TIMER_W-1:0] HIGH_T = TIMER_W'(HIGH_TICKS);

    logic               r_pulse;
    logic               r_dir;
    logic               r_up;
    logic [31:0]        r_pos;
    logic [31:0]        r_left;
    logic [TIMER_W-1:0] r_tmr;

    logic               n_pulse;
    logic               n_dir;
    logic               n_up;
    logic [31:0]        n_pos;
    logic [31:0]        n_left;
    logic [TIMER_W-1:0] n_tmr;
    logic               rej;
    logic               busy;

    assign busy  = (r_left != '0);
    assign o_pop = i_valid && !i_out_full;

    always_comb begin
        logic [TIMER_W-1:0] tmr;
        logic               fin;

        n_pulse = r_pulse;
        n_dir   = r_dir;
        n_up    = r_up;
        n_pos   = r_pos;
        n_left  = r_left;
        n_tmr   = r_tmr;
        rej     = 1'b0;
        fin     = 1'b0;
        tmr     = r_tmr;

        case (i_cmd.kind)
            K_MOVE: begin
                if (busy) begin
                    rej = 1'b1;
                end else if (i_cmd.steps != '0) begin
                    n_up    = !i_cmd.neg;
                    n_dir   = !i_cmd.neg ^ i_dir_invert;
                    n_left  = i_cmd.steps;
                    n_pulse = 1'b1;
                    n_tmr   = HIGH_T;
                end
            end
            K_TICK: begin
                if (busy) begin
                    if (tmr != '0) begin
                        tmr = tmr - TIMER_W'(1);
                    end
                    n_tmr = tmr;
                    if (tmr == '0) begin
                        if (r_pulse) begin
                            n_pulse = 1'b0;
                            n_tmr   = i_low_time;
                            fin     = (i_low_time == '0);
                        end else begin
                            fin = 1'b1;
                        end
                    end
                end
            end
            K_ZERO: n_pos = '0;
            K_STOP: begin
                n_left  = '0;
                n_pulse = 1'b0;
                n_tmr   = '0;
            end
            default: ;
        endcase

        // end of one step
        if (fin) begin
            n_pos   = r_pos + (r_up ? 32'd1 : 32'hFFFF_FFFF);
            n_left  = r_left - 32'd1;
            n_pulse = (r_left != 32'd1);
            n_tmr   = (r_left != 32'd1) ? HIGH_T : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse <= 1'b0;
            r_dir   <= 1'b0;
            r_up    <= 1'b1;
            r_pos   <= '0;
            r_left  <= '0;
            r_tmr   <= '0;
        end else if (o_pop) begin
            r_pulse <= n_pulse;
            r_dir   <= n_dir;
            r_up    <= n_up;
            r_pos   <= n_pos;
            r_left  <= n_left;
            r_tmr   <= n_tmr;
        end
    end

    always_comb begin
        o_word.step_level = n_pulse;
        o_word.direction  = n_dir;
        o_word.enable_n   = !i_drive_en;
        o_word.position   = n_pos;
        o_word.busy_res   = (n_left != '0);
        o_word.rejected   = rej;
    end

endmodule

// File: rtl/step_dir_pulse_generator_top.sv
`timescale 1ns / 1ps

// Step/direction pulse generator. Each input word is a 1 us tick, a move
// (steps, degrees truncated toward zero, or revolutions), a position clear
// or a stop, and each produces exactly one result word with the step, dir
// and enable levels, the position counter, busy and a reject flag (move
// refused while busy). Throughput is one word per clock, sustained, as long
// as results are popped; a word's result reaches the result port through
// the 11 front stages that turn degrees/revolutions into a step count (two
// reciprocal multiplies by 1/360), the command queue, and the executing
// back end writing the result queue. After every register write the low
// time TICKS_PER_MINUTE / (rpm * steps per revolution) is recomputed by a
// bit-serial divider; full stays high while it runs. Write registers only
// when no results are pending.
module step_dir_pulse_generator_top
    import sdp_pkg::*;
#(
    parameter int HIGH_TICKS       = HIGH_TICKS_DEF,
    parameter int TICKS_PER_MINUTE = TICKS_PER_MIN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input word queue side
    input  logic        push,
    output logic        full,
    input  t_in_word    i_word,
    // result word queue side
    output logic        empty,
    input  logic        pop,
    output t_out_word   o_word,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CRED_W = $clog2(MID_DEPTH + 1);

    // configuration registers
    logic [15:0] r_spr;
    logic [15:0] r_rpm;
    logic [15:0] r_spr_eff;   // a written zero acts as 200
    logic [15:0] r_rpm_eff;   // a written zero acts as 1
    logic        r_dir_inv;
    logic        r_drv_en;
    logic        r_div_start;
    logic        cfg_wr;

    // words in the front pipeline plus command queue
    logic [CRED_W-1:0] r_credit;
    logic              in_acc;

    logic               div_busy;
    logic [TIMER_W-1:0] low_time;

    logic      fr_valid;
    t_cmd      fr_cmd;
    logic      mid_full;
    logic      mid_empty;
    t_cmd      mid_cmd;
    logic      bk_pop;
    t_out_word bk_word;
    logic      out_full;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Front stalls on nothing: accept only while a queue slot can be reserved and the divider is idle.
    assign full   = div_busy || (r_credit == CRED_W'(MID_DEPTH));
    assign in_acc = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spr       <= 16'(SPR_DEF);
            r_rpm       <= 16'(RPM_DEF);
            r_spr_eff   <= 16'(SPR_DEF);
            r_rpm_eff   <= 16'(RPM_DEF);
            r_dir_inv   <= 1'b0;
            r_drv_en    <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= cfg_wr;
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    REG_SPR: begin
                        r_spr     <= pwdata[15:0];
                        r_spr_eff <= (pwdata[15:0] == '0) ? 16'(SPR_DEF) : pwdata[15:0];
                    end
                    REG_RPM: begin
                        r_rpm     <= pwdata[15:0];
                        r_rpm_eff <= (pwdata[15:0] == '0) ? 16'd1 : pwdata[15:0];
                    end
                    REG_DIR_INV: r_dir_inv <= pwdata[0];
                    REG_DRV_EN:  r_drv_en  <= pwdata[0];
                endcase
            end
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SPR:     prdata = {16'b0, r_spr};
            REG_RPM:     prdata = {16'b0, r_rpm};
            REG_DIR_INV: prdata = {31'b0, r_dir_inv};
            REG_DRV_EN:  prdata = {31'b0, r_drv_en};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            case ({in_acc, bk_pop})
                2'b10:   r_credit <= r_credit + CRED_W'(1);
                2'b01:   r_credit <= r_credit - CRED_W'(1);
                default: r_credit <= r_credit;
            endcase
        end
    end

    sdp_div #(
        .TICKS_PER_MINUTE(TICKS_PER_MINUTE)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_div_start),
        .i_spr     (r_spr_eff),
        .i_rpm     (r_rpm_eff),
        .o_busy    (div_busy),
        .o_low_time(low_time)
    );

    sdp_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(in_acc),
        .i_word (i_word),
        .i_spr  (r_spr_eff),
        .o_valid(fr_valid),
        .o_cmd  (fr_cmd)
    );

    // Command queue; credits keep it from overflowing.
    sdp_fifo #(
        .WIDTH($bits(t_cmd)),
        .DEPTH(MID_DEPTH)
    ) u_mid_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (fr_valid),
        .i_data (fr_cmd),
        .o_full (mid_full),
        .i_pop  (bk_pop),
        .o_data (mid_cmd),
        .o_empty(mid_empty)
    );

    sdp_back #(
        .HIGH_TICKS(HIGH_TICKS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (!mid_empty && !mid_full || !mid_empty),
        .i_cmd       (mid_cmd),
        .i_out_full  (out_full),
        .i_low_time  (low_time),
        .i_dir_invert(r_dir_inv),
        .i_drive_en  (r_drv_en),
        .o_pop       (bk_pop),
        .o_word      (bk_word)
    );

    // Result queue parts the executor from the consumer.
    sdp_fifo #(
        .WIDTH($bits(t_out_word)),
        .DEPTH(OUT_DEPTH)
    ) u_out_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (bk_pop),
        .i_data (bk_word),
        .o_full (out_full),
        .i_pop  (pop),
        .o_data (o_word),
        .o_empty(empty)
    );

endmodule

// File: tb/step_dir_pulse_generator_top_tb.sv
`timescale 1ns / 1ps

module step_dir_pulse_generator_top_tb;
    import sdp_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 8;
    localparam int HOLD_CYCLES     = 400;   // long receiver hold-off, fills both queues
    localparam int DRAIN_TAIL      = 20;    // margin past the pipeline
    localparam int RANDOM_PHASES   = 5;
    localparam int WORDS_PER_PHASE = 190;
    localparam int PRESSURE_WORDS  = 150;
    localparam int TIMEOUT_NS      = 1_000_000;
    localparam int GAP_PERCENT     = 7;

    // modes 6 and 7 have no meaning: no state change, no time step
    localparam logic [2:0] MODE_RSVD6 = 3'd6;
    localparam logic [2:0] MODE_RSVD7 = 3'd7;

    // ------------------------------------------------------------------
    // DUT connections, all inputs known from time zero
    // ------------------------------------------------------------------
    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push    = 1'b0;
    logic        full;
    t_in_word    i_word  = '0;
    logic        empty;
    logic        pop     = 1'b0;
    t_out_word   o_word;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    step_dir_pulse_generator_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_word  (i_word),
        .empty   (empty),
        .pop     (pop),
        .o_word  (o_word),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shared run state
    // ------------------------------------------------------------------
    t_out_word pending_status[$];   // predicted result words, oldest first
    int  mismatches    = 0;
    int  words_sent    = 0;
    int  results_seen  = 0;
    int  reg_writes    = 0;
    int  steps_done    = 0;
    int  moves_refused = 0;
    int  input_stalls  = 0;
    int  hold_request  = 0;         // cycles of receiver hold-off asked by a test
    logic hold_active  = 1'b0;
    bit  gapless       = 1'b0;      // no random idling on either side

    // ------------------------------------------------------------------
    // Motor predictor: registers and stepping state, updated per word
    // ------------------------------------------------------------------
    logic [15:0]        spr_reg    = 16'(SPR_DEF);
    logic [15:0]        rpm_reg    = 16'(RPM_DEF);
    logic               inv_reg    = 1'b0;
    logic               en_reg     = 1'b0;
    logic [31:0]        pos_count  = '0;
    logic [31:0]        steps_todo = '0;
    logic [TIMER_W-1:0] phase_left = '0;
    logic [TIMER_W-1:0] low_ticks  = '0;
    logic               step_high  = 1'b0;
    logic               dir_line   = 1'b0;
    logic               count_up   = 1'b1;

    // zero steps/rev behaves as the default everywhere
    function automatic int eff_spr();
        return (spr_reg == 16'd0) ? SPR_DEF : int'(spr_reg);
    endfunction

    function automatic void refresh_low_ticks();
        longint prod;
        prod = longint'((rpm_reg == 16'd0) ? 1 : int'(rpm_reg)) * longint'(eff_spr());
        low_ticks = TIMER_W'(longint'(TICKS_PER_MIN_DEF) / prod);
    endfunction

    // end of one step: position moves, next step starts high unless done
    function automatic void end_step();
        pos_count  = count_up ? pos_count + 32'd1 : pos_count - 32'd1;
        steps_todo = steps_todo - 32'd1;
        steps_done++;
        step_high  = (steps_todo != 32'd0);
        phase_left = (steps_todo != 32'd0) ? TIMER_W'(HIGH_TICKS_DEF) : '0;
    endfunction

    function automatic void run_tick();
        if (steps_todo == 32'd0)
            return;
        if (phase_left != '0)
            phase_left = phase_left - TIMER_W'(1);
        if (phase_left != '0)
            return;
        if (step_high) begin
            step_high  = 1'b0;
            phase_left = low_ticks;
            if (phase_left == '0)
                end_step();
        end else begin
            end_step();
        end
    endfunction

    function automatic void start_move(input logic [31:0] n);
        if (n == 32'd0)
            return;
        count_up   = ~n[31];
        dir_line   = ~n[31] ^ inv_reg;
        steps_todo = n[31] ? 32'd0 - n : n;
        step_high  = 1'b1;
        phase_left = TIMER_W'(HIGH_TICKS_DEF);
    endfunction

    function automatic t_out_word predict_status(input t_in_word w);
        t_out_word r;
        longint    amt;
        logic      refused;
        amt     = longint'($signed(w.amount));
        refused = 1'b0;
        case (w.mode)
            MODE_TICK: run_tick();
            MODE_STEPS, MODE_DEG, MODE_REV: begin
                if (steps_todo != 32'd0) begin
                    refused = 1'b1;
                    moves_refused++;
                end else if (w.mode == MODE_STEPS) begin
                    start_move(w.amount);
                end else if (w.mode == MODE_DEG) begin
                    start_move(32'(amt * longint'(eff_spr()) / longint'(DEG_PER_REV)));
                end else begin
                    start_move(32'(amt * longint'(eff_spr())));
                end
            end
            MODE_ZERO: pos_count = '0;
            MODE_STOP: begin
                steps_todo = '0;
                step_high  = 1'b0;
                phase_left = '0;
            end
            default: ;
        endcase
        r.step_level = step_high;
        r.direction  = dir_line;
        r.enable_n   = ~en_reg;
        r.position   = pos_count;
        r.busy_res   = (steps_todo != 32'd0);
        r.rejected   = refused;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic flag_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] result %0d: %s expected 0x%08h, got 0x%08h",
                     $time, results_seen, field, want, got);
    endtask

    task automatic check_result(input t_out_word got);
        t_out_word want;
        results_seen++;
        if (pending_status.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] result %0d arrived with nothing pending", $time, results_seen);
            return;
        end
        want = pending_status.pop_front();
        if (got.step_level !== want.step_level)
            flag_field("step_level", want.step_level, got.step_level);
        if (got.direction !== want.direction)
            flag_field("direction", want.direction, got.direction);
        if (got.enable_n !== want.enable_n)
            flag_field("enable_n", want.enable_n, got.enable_n);
        if (got.position !== want.position)
            flag_field("position", want.position, got.position);
        if (got.busy_res !== want.busy_res)
            flag_field("busy_res", want.busy_res, got.busy_res);
        if (got.rejected !== want.rejected)
            flag_field("rejected", want.rejected, got.rejected);
    endtask

    // Receiver: takes a word on pop && !empty, idles ~7% unless held off or gapless
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty)
                check_result(o_word);
            if (push && full)
                input_stalls++;
            pop <= !hold_active && !(!gapless && $urandom_range(99) < GAP_PERCENT);
        end
    end

    // Hold-off counter, its own process so the sender keeps pushing meanwhile
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_active <= 1'b1;
                repeat (hold_request) @(posedge i_clk);
                hold_active  <= 1'b0;
                hold_request = 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // push stays high after acceptance; the next call either keeps it or idles
    task automatic send_word(input logic [2:0] mode, input logic [31:0] amount);
        t_in_word w;
        w.mode   = mode;
        w.amount = amount;
        while (!gapless && $urandom_range(99) < GAP_PERCENT) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        i_word <= w;
        push   <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        pending_status.push_back(predict_status(w));
        words_sent++;
    endtask

    // sender pause: nothing offered until every result is back
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_status.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // APB write, then read back; block must be drained first
    task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] back;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_SPR:     spr_reg = val[15:0];
            REG_RPM:     rpm_reg = val[15:0];
            REG_DIR_INV: inv_reg = val[0];
            REG_DRV_EN:  en_reg  = val[0];
            default: ;
        endcase
        refresh_low_ticks();
        reg_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        back = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (back !== val)
            flag_field("register readback", val, back);
    endtask

    task automatic apply_config(input logic [15:0] spr, input logic [15:0] rpm,
                                input logic inv, input logic en);
        drain();
        set_reg(REG_SPR, {16'd0, spr});
        set_reg(REG_RPM, {16'd0, rpm});
        set_reg(REG_DIR_INV, {31'd0, inv});
        set_reg(REG_DRV_EN, {31'd0, en});
    endtask

    function automatic logic [31:0] small_signed(input int unsigned lim);
        int v;
        v = int'($urandom_range(lim, 0));
        return $urandom_range(1) ? 32'(-v) : 32'(v);
    endfunction

    // Mostly move-then-ticks sequences; the rest is stops, clears, refused
    // moves, full-range amounts and meaningless modes.
    function automatic t_in_word pick_word();
        t_in_word    w;
        int unsigned r;
        r        = $urandom_range(99);
        w.amount = $urandom;
        if (steps_todo == 32'd0) begin
            if (r < 40) begin
                w.mode   = MODE_STEPS;
                w.amount = small_signed(6);
            end else if (r < 50) begin
                w.mode   = MODE_DEG;
                w.amount = small_signed(4);
            end else if (r < 53) begin
                w.mode   = MODE_REV;
                w.amount = small_signed(2);
            end else if (r < 58) begin
                w.mode = 3'($urandom_range(MODE_REV, MODE_STEPS));
            end else if (r < 80) begin
                w.mode = MODE_TICK;
            end else if (r < 87) begin
                w.mode = MODE_ZERO;
            end else if (r < 94) begin
                w.mode = MODE_STOP;
            end else begin
                w.mode = 3'($urandom_range(MODE_RSVD7, MODE_RSVD6));
            end
        end else begin
            if (r < 86)
                w.mode = MODE_TICK;
            else if (r < 90)
                w.mode = MODE_STOP;
            else if (r < 95)
                w.mode = 3'($urandom_range(MODE_REV, MODE_STEPS));
            else if (r < 98)
                w.mode = MODE_ZERO;
            else
                w.mode = 3'($urandom_range(MODE_RSVD7, MODE_RSVD6));
        end
        return w;
    endfunction

    task automatic send_random(input int count);
        t_in_word w;
        repeat (count) begin
            w = pick_word();
            send_word(w.mode, w.amount);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset registers (5 ms low phase): every mode, zero-length moves,
    // refusals while busy, extreme amounts in all three move units.
    task automatic test_basic_modes();
        send_word(MODE_TICK, 32'hFFFF_FFFF);     // idle tick
        send_word(MODE_STEPS, 32'd0);            // zero-length move
        send_word(MODE_DEG, 32'd1);              // 200/360 truncates to zero
        send_word(MODE_DEG, 32'hFFFF_FFFF);      // -200/360 truncates toward zero
        send_word(MODE_STEPS, 32'd3);
        send_word(MODE_STEPS, 32'd5);            // refused while busy
        send_word(MODE_DEG, 32'd0);              // refused even at zero length
        send_word(MODE_TICK, 32'd0);
        send_word(MODE_TICK, 32'd0);             // high phase over
        send_word(MODE_ZERO, 32'h1234_5678);     // clear, move keeps running
        send_word(MODE_RSVD6, $urandom);
        send_word(MODE_RSVD7, $urandom);
        send_word(MODE_STOP, 32'd0);
        send_word(MODE_TICK, 32'd0);
        send_word(MODE_STEPS, 32'h8000_0000);    // most negative count
        send_word(MODE_REV, 32'd1);              // refused
        send_word(MODE_STOP, 32'd0);
        send_word(MODE_STEPS, 32'h7FFF_FFFF);
        send_word(MODE_STOP, 32'd0);
        send_word(MODE_DEG, 32'h8000_0000);
        send_word(MODE_STOP, 32'd0);
        send_word(MODE_DEG, 32'h7FFF_FFFF);
        send_word(MODE_STOP, 32'd0);
        send_word(MODE_REV, 32'h8000_0000);      // product wraps to zero steps
        send_word(MODE_REV, 32'h7FFF_FFFF);
        send_word(MODE_STOP, 32'd0);
    endtask

    // Top speed: low time is zero, so a step ends with its high phase.
    task automatic test_fast_steps();
        apply_config(16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
        send_word(MODE_STEPS, 32'd3);
        repeat (7) send_word(MODE_TICK, $urandom);
        send_word(MODE_STEPS, 32'hFFFF_FFFE);    // two steps back
        repeat (5) send_word(MODE_TICK, $urandom);
        send_word(MODE_DEG, 32'd360);
        repeat (5) send_word(MODE_TICK, $urandom);
        send_word(MODE_STOP, 32'd0);
        send_word(MODE_REV, 32'hFFFF_FFFF);
        repeat (4) send_word(MODE_TICK, $urandom);
        send_word(MODE_ZERO, 32'd0);
        send_word(MODE_STOP, 32'd0);
        send_word(MODE_TICK, 32'd0);
    endtask

    // Zero registers fall back to defaults; then the slowest setting.
    task automatic test_register_extremes();
        apply_config(16'd0, 16'd0, 1'b0, 1'b1);
        send_word(MODE_DEG, 32'd360);
        repeat (3) send_word(MODE_TICK, $urandom);
        send_word(MODE_STOP, 32'd0);
        send_word(MODE_REV, 32'd1);
        send_word(MODE_STOP, 32'd0);
        send_word(MODE_DEG, 32'hFFFF_FF4D);      // -179 degrees
        send_word(MODE_STOP, 32'd0);
        apply_config(16'd1, 16'd1, 1'b1, 1'b0);
        send_word(MODE_DEG, 32'd360);
        repeat (4) send_word(MODE_TICK, $urandom);
        send_word(MODE_REV, 32'h7FFF_FFFF);      // refused, still busy
        send_word(MODE_STOP, 32'd0);
        send_word(MODE_REV, 32'h7FFF_FFFF);
        send_word(MODE_STOP, 32'd0);
    endtask

    // Speed change while steps remain: the running phase keeps its length.
    task automatic test_retime_mid_move();
        apply_config(16'd1000, 16'd10000, 1'b0, 1'b1);
        send_word(MODE_STEPS, 32'd4);
        repeat (5) send_word(MODE_TICK, $urandom);
        drain();
        set_reg(REG_RPM, 32'd30000);
        repeat (30) send_word(MODE_TICK, $urandom);
    endtask

    // Receiver held off long enough for the input side to stall.
    task automatic test_backpressure();
        apply_config(16'd2000, 16'd30000, 1'b0, 1'b1);
        hold_request = HOLD_CYCLES;
        send_random(PRESSURE_WORDS);
        drain();
    endtask

    task automatic test_random_traffic();
        int unsigned rpm;
        int unsigned lt;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0) begin
                apply_config(16'hFFFF, 16'hFFFF, 1'($urandom_range(1)), 1'($urandom_range(1)));
            end else begin
                // aim for a low phase of 1..12 ticks
                rpm = $urandom_range(65535, 30000);
                lt  = $urandom_range(12, 1);
                apply_config(16'(TICKS_PER_MIN_DEF / (lt * rpm)), 16'(rpm),
                             1'($urandom_range(1)), 1'($urandom_range(1)));
            end
            gapless = (p == 2);
            send_random(WORDS_PER_PHASE);
            gapless = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        refresh_low_ticks();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_modes();
        test_fast_steps();
        test_register_extremes();
        test_retime_mid_move();
        test_backpressure();
        test_random_traffic();

        drain();
        repeat (DRAIN_TAIL) @(posedge i_clk);

        $display("Covered %0d words and %0d register writes, input stalled %0d cycles.",
                 words_sent, reg_writes, input_stalls);
        $display("%0d steps played out, %0d moves refused.", steps_done, moves_refused);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results still pending", pending_status.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
